>>> src/interval_histogram_mode_finder_assert.svh
// Assertion macros used by the interval histogram back end (ihm_back).
`ifndef INTERVAL_HISTOGRAM_MODE_FINDER_ASSERT_SVH
`define INTERVAL_HISTOGRAM_MODE_FINDER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define IHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define IHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> src/ihm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_pkg
// Shared types and constants of the interval histogram mode finder.
// ---------------------------------------------------------------------------
package ihm_pkg;
   localparam int NB = 64;
   localparam int IW = 6;
   localparam int CW = 32;
   localparam logic [CW-1:0] CMAX = '1;

   localparam logic [2:0] CMD_STAMP = 3'd0;
   localparam logic [2:0] CMD_RD_COARSE = 3'd1;
   localparam logic [2:0] CMD_RD_FINE = 3'd2;
   localparam logic [2:0] CMD_MODES = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   localparam logic [1:0] REG_ENABLED = 2'd0;
   localparam logic [1:0] REG_COARSE = 2'd1;
   localparam logic [1:0] REG_BASE = 2'd2;
   localparam logic [1:0] REG_FINE = 2'd3;

   typedef struct packed {
      logic [2:0] cmd;
      logic [63:0] stamp;
      logic [IW-1:0] bucket_index;
   } item_type;

   typedef struct packed {
      logic [CW-1:0] bucket_count;
      logic modes_found;
      logic [IW-1:0] first_mode_index;
      logic [IW-1:0] second_mode_index;
      logic [47:0] first_mode_center;
      logic [47:0] second_mode_center;
      logic [47:0] mode_separation;
      logic bimodal;
   } result_type;
endpackage

>>> src/ihm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module ihm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> src/ihm_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_fifo
// Two-entry queue between the request stream and the back part.
// ---------------------------------------------------------------------------
module ihm_fifo import ihm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  item_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output item_type out_data
);
   item_type data_ff [2];
   logic [1:0] cnt_ff;
   logic rp_ff, wp_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = data_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         data_ff[wp_ff] <= in_data;
      end
   end
endmodule

>>> src/ihm_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_divider
// Restoring divider of a 64-bit dividend by a 32-bit divisor, one bit a cycle,
// giving the full 64-bit quotient.
// ---------------------------------------------------------------------------
module ihm_divider import ihm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff;
   logic [32:0] r_ff;
   logic [31:0] d_ff;
   logic [6:0] n_ff;
   logic busy_ff, done_ff;
   logic [32:0] sh;
   logic ge;
   assign sh = {r_ff[31:0], q_ff[63]};
   assign ge = sh >= {1'b0, d_ff};
   assign done = done_ff;
   assign quotient = q_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff <= '0;
         end else if (busy_ff) begin
            n_ff <= n_ff + 7'd1;
            if (n_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         r_ff <= ge ? sh - {1'b0, d_ff} : sh;
         q_ff <= {q_ff[62:0], ge};
      end
   end
endmodule

>>> src/ihm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_back
// Executes queued commands: binning, reads, clearing and the peak scan.
// ---------------------------------------------------------------------------
module ihm_back import ihm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  item_type in_data,
   input  logic enabled,
   input  logic cfg_clear,
   input  logic [31:0] coarse_ticks,
   input  logic [31:0] base_ticks,
   input  logic [31:0] fine_ticks,
   output logic out_valid,
   input  logic out_ready,
   output result_type out_data
);
`include "interval_histogram_mode_finder_assert.svh"
   typedef enum logic [3:0] {
      S_IDLE, S_WIPE, S_DIVC, S_DIVF, S_RDC, S_UPC, S_RDF, S_UPF,
      S_READ, S_READ2, S_SCAN1, S_SCAN2, S_FIN1, S_FIN2, S_OUT
   } state_type;
   state_type st_ff;
   item_type it_ff;
   result_type res_ff;
   logic [63:0] prev_ff, d_ff;
   logic have_ff, pend_clear_ff;
   logic [IW:0] cnt_ff;
   logic [IW-1:0] ci_ff, fi_ff, first_ff, second_ff;
   logic [CW-1:0] fbest_ff, sbest_ff;
   logic have2_ff;
   logic [47:0] c1_ff, c2_ff;
   logic [31:0] fw;
   logic div_start, div_done;
   logic [63:0] div_num, div_q;
   logic [31:0] div_den;
   logic c_we, f_we;
   logic [IW-1:0] c_addr, f_addr;
   logic [CW-1:0] c_wd, f_wd, c_rd, f_rd;
   logic [IW-1:0] ridx;
   logic excl;

   ihm_divider u_div (.clock, .reset, .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q));
   ihm_ram #(.WIDTH(CW), .DEPTH(NB)) u_coarse (.clock, .wr_en(c_we),
      .addr(c_addr), .wr_data(c_wd), .rd_data(c_rd));
   ihm_ram #(.WIDTH(CW), .DEPTH(NB)) u_fine (.clock, .wr_en(f_we),
      .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd));

   assign fw = (fine_ticks == '0) ? 32'd1 : fine_ticks;
   assign in_ready = st_ff == S_IDLE && !pend_clear_ff;
   assign out_valid = st_ff == S_OUT;
   assign out_data = res_ff;
   assign ridx = cnt_ff[IW-1:0] - 1'b1;
   assign excl = ({1'b0, ridx} + 7'd2 >= {1'b0, first_ff})
      && ({1'b0, ridx} <= {1'b0, first_ff} + 7'd2);

   always_comb begin
      div_start = 1'b0;
      div_num = d_ff;
      div_den = (coarse_ticks == '0) ? 32'd1 : coarse_ticks;
      if (st_ff == S_IDLE && in_valid && in_ready && in_data.cmd == CMD_STAMP
            && enabled && have_ff) begin
         div_start = 1'b1;
         div_num = in_data.stamp - prev_ff;
      end else if (st_ff == S_DIVC && div_done) begin
         div_start = 1'b1;
         div_num = d_ff - {32'd0, base_ticks};
         div_den = fw;
      end
      c_we = 1'b0;
      f_we = 1'b0;
      c_wd = '0;
      f_wd = '0;
      c_addr = it_ff.bucket_index;
      f_addr = it_ff.bucket_index;
      unique case (st_ff)
         S_WIPE: begin
            c_we = 1'b1;
            f_we = 1'b1;
            c_addr = cnt_ff[IW-1:0];
            f_addr = cnt_ff[IW-1:0];
         end
         S_RDC, S_UPC: begin
            c_addr = ci_ff;
            c_we = st_ff == S_UPC;
            c_wd = (c_rd == CMAX) ? c_rd : c_rd + 1'b1;
         end
         S_RDF, S_UPF: begin
            f_addr = fi_ff;
            f_we = st_ff == S_UPF;
            f_wd = (f_rd == CMAX) ? f_rd : f_rd + 1'b1;
         end
         S_SCAN1, S_SCAN2: f_addr = cnt_ff[IW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_WIPE;
         cnt_ff <= '0;
         have_ff <= 1'b0;
         prev_ff <= '0;
         pend_clear_ff <= 1'b0;
         it_ff <= '0;
      end else begin
         pend_clear_ff <= cfg_clear || (pend_clear_ff && st_ff != S_IDLE);
         unique case (st_ff)
            S_IDLE: begin
               if (pend_clear_ff) begin
                  have_ff <= 1'b0;
                  prev_ff <= '0;
                  cnt_ff <= '0;
                  it_ff <= '0;
                  st_ff <= S_WIPE;
               end else if (in_valid) begin
                  it_ff <= in_data;
                  res_ff <= '0;
                  cnt_ff <= '0;
                  unique case (in_data.cmd)
                     CMD_STAMP: begin
                        if (enabled) begin
                           prev_ff <= in_data.stamp;
                           have_ff <= 1'b1;
                           d_ff <= in_data.stamp - prev_ff;
                        end
                        st_ff <= (enabled && have_ff) ? S_DIVC : S_OUT;
                     end
                     CMD_RD_COARSE, CMD_RD_FINE: st_ff <= S_READ;
                     CMD_MODES: begin
                        fbest_ff <= '0;
                        sbest_ff <= '0;
                        first_ff <= '0;
                        second_ff <= '0;
                        have2_ff <= 1'b0;
                        st_ff <= S_SCAN1;
                     end
                     CMD_CLEAR: begin
                        have_ff <= 1'b0;
                        prev_ff <= '0;
                        st_ff <= S_WIPE;
                     end
                     default: st_ff <= S_OUT;
                  endcase
               end
            end
            S_WIPE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (IW+1)'(NB - 1)) begin
                  st_ff <= (it_ff.cmd == CMD_CLEAR) ? S_OUT : S_IDLE;
               end
            end
            S_DIVC: begin
               if (div_done) begin
                  ci_ff <= (d_ff[63] || div_q > 64'(NB - 1)) ?
                     (d_ff[63] ? '0 : IW'(NB - 1)) : div_q[IW-1:0];
                  st_ff <= S_DIVF;
               end
            end
            S_DIVF: begin
               if (div_done) begin
                  if (d_ff[63] || d_ff < {32'd0, base_ticks}) begin
                     fi_ff <= '0;
                  end else if (div_q > 64'(NB - 1)) begin
                     fi_ff <= IW'(NB - 1);
                  end else begin
                     fi_ff <= div_q[IW-1:0];
                  end
                  st_ff <= S_RDC;
               end
            end
            S_RDC: st_ff <= S_UPC;
            S_UPC: st_ff <= S_RDF;
            S_RDF: st_ff <= S_UPF;
            S_UPF: st_ff <= S_OUT;
            S_READ: st_ff <= S_READ2;
            S_READ2: begin
               res_ff.bucket_count <= (it_ff.cmd == CMD_RD_COARSE) ? c_rd : f_rd;
               st_ff <= S_OUT;
            end
            S_SCAN1: begin
               if (cnt_ff != '0 && f_rd > fbest_ff) begin
                  fbest_ff <= f_rd;
                  first_ff <= ridx;
               end
               if (cnt_ff == (IW+1)'(NB)) begin
                  cnt_ff <= '0;
                  st_ff <= S_SCAN2;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_SCAN2: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff != '0 && !excl && (!have2_ff || f_rd > sbest_ff)) begin
                  sbest_ff <= f_rd;
                  second_ff <= ridx;
                  have2_ff <= 1'b1;
               end
               if (cnt_ff == (IW+1)'(NB)) begin
                  st_ff <= S_FIN1;
               end
            end
            S_FIN1: begin
               c1_ff <= 48'(base_ticks) + 48'(first_ff) * 48'(fine_ticks)
                  + 48'(fine_ticks >> 1);
               c2_ff <= 48'(base_ticks) + 48'(second_ff) * 48'(fine_ticks)
                  + 48'(fine_ticks >> 1);
               st_ff <= S_FIN2;
            end
            S_FIN2: begin
               if (fbest_ff != '0 && have2_ff && sbest_ff != '0) begin
                  res_ff.modes_found <= 1'b1;
                  res_ff.first_mode_index <= first_ff;
                  res_ff.second_mode_index <= second_ff;
                  res_ff.first_mode_center <= c1_ff;
                  res_ff.second_mode_center <= c2_ff;
                  res_ff.mode_separation <= (c1_ff > c2_ff) ? c1_ff - c2_ff
                     : c2_ff - c1_ff;
                  res_ff.bimodal <= {sbest_ff, 2'b00} >= {2'b00, fbest_ff};
               end
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_ready) begin
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `IHM_ASSERT_IMP(a_no_accept_busy, clock, reset, st_ff != S_IDLE, !in_ready)
   `IHM_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid)
   `IHM_ASSERT_IMP(a_bump_only_update, clock, reset, c_we && st_ff != S_WIPE,
      st_ff == S_UPC)
endmodule

>>> src/ihm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ihm_front
// Holds the configuration registers and flags changes of the enable bit.
// ---------------------------------------------------------------------------
module ihm_front import ihm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata,
   output logic enabled,
   output logic cfg_clear,
   output logic [31:0] coarse_ticks,
   output logic [31:0] base_ticks,
   output logic [31:0] fine_ticks
);
   logic en_ff;
   logic [31:0] co_ff, ba_ff, fi_ff;
   assign enabled = en_ff;
   assign coarse_ticks = co_ff;
   assign base_ticks = ba_ff;
   assign fine_ticks = fi_ff;
   assign cfg_clear = csr_we && csr_index == REG_ENABLED && csr_wdata[0] != en_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         co_ff <= 32'd1000;
         ba_ff <= '0;
         fi_ff <= 32'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLED: en_ff <= csr_wdata[0];
            REG_COARSE: co_ff <= csr_wdata;
            REG_BASE: ba_ff <= csr_wdata;
            REG_FINE: fi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end
endmodule

>>> src/interval_histogram_mode_finder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_histogram_mode_finder
// Interval histogram with peak detection.
// ---------------------------------------------------------------------------
// Requests pass through a two-entry queue to a sequencer that handles one
// command at a time. An enabled timestamp event with a previous stamp held is
// binned after two bit-serial divisions; a mode query makes two scans of the
// 64-entry fine histogram RAM; a clear, an enable change and reset each sweep
// both RAMs.
module interval_histogram_mode_finder import ihm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [79:0] req_tdata,  // cmd[2:0], stamp[66:3], bucket_index[72:67]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [191:0] rsp_tdata, // bucket_count, modes_found, first/second index,
                                   // first/second centre, separation, bimodal
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   item_type qin, qout;
   logic qv, qr;
   logic enabled, cfg_clear;
   logic [31:0] co, ba, fi;
   result_type res;
   assign qin.cmd = req_tdata[2:0];
   assign qin.stamp = req_tdata[66:3];
   assign qin.bucket_index = req_tdata[72:67];
   assign rsp_tdata = {2'b00, res.bimodal, res.mode_separation,
      res.second_mode_center, res.first_mode_center, res.second_mode_index,
      res.first_mode_index, res.modes_found, res.bucket_count};

   ihm_front u_front (.clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .enabled, .cfg_clear, .coarse_ticks(co), .base_ticks(ba), .fine_ticks(fi));
   ihm_fifo u_fifo (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(qin), .out_valid(qv), .out_ready(qr), .out_data(qout));
   ihm_back u_back (.clock, .reset, .in_valid(qv), .in_ready(qr), .in_data(qout),
      .enabled, .cfg_clear, .coarse_ticks(co), .base_ticks(ba), .fine_ticks(fi),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res));
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval histogram mode finder testbench
// Drives timestamp events, bucket reads, mode queries and clears through the
// request stream, predicts every response from a model of both histograms
// and compares each response transfer field by field. Several register
// settings and several patterns of idling and back-pressure are covered.
// ---------------------------------------------------------------------------
module testbench;
   import ihm_pkg::*;

   class interval_histogram_scoreboard;
      logic [31:0] coarse_hist [NB];
      logic [31:0] fine_hist [NB];
      logic [63:0] last_stamp;
      bit          stamp_held;
      logic        enabled;
      logic [31:0] coarse_width;
      logic [31:0] fine_base;
      logic [31:0] fine_width;
      logic [191:0] expected_responses [$];
      int mismatches;
      int responses_checked;

      function void clear_histograms();
         for (int i = 0; i < NB; i++) begin
            coarse_hist[i] = '0;
            fine_hist[i] = '0;
         end
         last_stamp = '0;
         stamp_held = 0;
      endfunction

      function void reset_state();
         enabled = 0;
         coarse_width = 32'd1000;
         fine_base = '0;
         fine_width = 32'd100;
         mismatches = 0;
         responses_checked = 0;
         expected_responses.delete();
         clear_histograms();
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_ENABLED: begin
               if (value[0] != enabled) clear_histograms();
               enabled = value[0];
            end
            REG_COARSE: coarse_width = value;
            REG_BASE: fine_base = value;
            REG_FINE: fine_width = value;
            default: ;
         endcase
      endfunction

      function void bin_interval(logic [63:0] stamp);
         logic [63:0] span, cw, fw, cq, fq;
         int ci, fi;
         ci = 0;
         fi = 0;
         if (stamp_held) begin
            span = stamp - last_stamp;
            cw = (coarse_width == 0) ? 64'd1 : {32'd0, coarse_width};
            fw = (fine_width == 0) ? 64'd1 : {32'd0, fine_width};
            if (!span[63]) begin
               cq = span / cw;
               ci = (cq > NB - 1) ? NB - 1 : int'(cq);
               if (span >= {32'd0, fine_base}) begin
                  fq = (span - {32'd0, fine_base}) / fw;
                  fi = (fq > NB - 1) ? NB - 1 : int'(fq);
               end
            end
            if (coarse_hist[ci] != CMAX) coarse_hist[ci]++;
            if (fine_hist[fi] != CMAX) fine_hist[fi]++;
         end
         last_stamp = stamp;
         stamp_held = 1;
      endfunction

      function logic [191:0] predict_response(logic [79:0] req);
         logic [2:0]  cmd;
         logic [5:0]  idx;
         logic [191:0] rsp;
         int first, second;
         bit have_second;
         logic [63:0] c1, c2, sep;
         cmd = req[2:0];
         idx = req[72:67];
         rsp = '0;
         case (cmd)
            CMD_STAMP: if (enabled) bin_interval(req[66:3]);
            CMD_RD_COARSE: rsp[31:0] = coarse_hist[idx];
            CMD_RD_FINE: rsp[31:0] = fine_hist[idx];
            CMD_MODES: begin
               first = 0;
               second = 0;
               have_second = 0;
               for (int i = 1; i < NB; i++)
                  if (fine_hist[i] > fine_hist[first]) first = i;
               if (fine_hist[first] != 0) begin
                  for (int i = 0; i < NB; i++) begin
                     if (!(i + 2 >= first && i <= first + 2) &&
                         (!have_second || fine_hist[i] > fine_hist[second])) begin
                        second = i;
                        have_second = 1;
                     end
                  end
                  if (have_second && fine_hist[second] != 0) begin
                     c1 = {32'd0, fine_base} + 64'(first) * fine_width + fine_width / 2;
                     c2 = {32'd0, fine_base} + 64'(second) * fine_width + fine_width / 2;
                     sep = (c1 > c2) ? c1 - c2 : c2 - c1;
                     rsp[32] = 1'b1;
                     rsp[38:33] = first[5:0];
                     rsp[44:39] = second[5:0];
                     rsp[92:45] = c1[47:0];
                     rsp[140:93] = c2[47:0];
                     rsp[188:141] = sep[47:0];
                     rsp[189] = ({fine_hist[second], 2'b00} >= {2'b00, fine_hist[first]});
                  end
               end
            end
            CMD_CLEAR: clear_histograms();
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(logic [79:0] req);
         expected_responses.push_back(predict_response(req));
      endfunction

      function void report(string field, logic [63:0] want, logic [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, actual %0h", field, want, got);
      endfunction

      function void check_response(logic [191:0] got);
         logic [191:0] want;
         responses_checked++;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response transfer with none expected: %0h", got);
            return;
         end
         want = expected_responses.pop_front();
         if (want[31:0] !== got[31:0]) report("bucket_count", want[31:0], got[31:0]);
         if (want[32] !== got[32]) report("modes_found", want[32], got[32]);
         if (want[38:33] !== got[38:33]) report("first_mode_index", want[38:33], got[38:33]);
         if (want[44:39] !== got[44:39]) report("second_mode_index", want[44:39], got[44:39]);
         if (want[92:45] !== got[92:45]) report("first_mode_center", want[92:45], got[92:45]);
         if (want[140:93] !== got[140:93])
            report("second_mode_center", want[140:93], got[140:93]);
         if (want[188:141] !== got[188:141])
            report("mode_separation", want[188:141], got[188:141]);
         if (want[189] !== got[189]) report("bimodal", want[189], got[189]);
         if (got[191:190] !== 2'b00) report("padding", 0, got[191:190]);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   interval_histogram_scoreboard histogram_board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic [63:0] sent_stamp = '0;
   int items_sent = 0;

   always #5 clock = ~clock;

   interval_histogram_mode_finder i_dut (.*);

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) histogram_board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) histogram_board.check_response(rsp_tdata);
   end

   task automatic send_request(logic [2:0] cmd, logic [63:0] stamp, logic [5:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, idx, stamp, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cmd == CMD_STAMP) sent_stamp = stamp;
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (histogram_board.expected_responses.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      histogram_board.write_reg(index, value);
      repeat (2) @(negedge clock);
   endtask

   task automatic random_request(logic [63:0] center_a, logic [63:0] center_b,
                                 logic [63:0] width);
      int pick;
      logic [63:0] stamp;
      pick = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(9))
            0, 1, 2, 3: stamp = sent_stamp + center_a + $urandom_range(0, 2) * width;
            4, 5: stamp = sent_stamp + center_b + $urandom_range(0, 1) * width;
            6: stamp = sent_stamp + $urandom_range(0, 3) * width + $urandom_range(7);
            7: stamp = sent_stamp - $urandom_range(1, 5000);
            8: stamp = {$urandom, $urandom};
            default: stamp = sent_stamp + {$urandom, $urandom} >> $urandom_range(63);
         endcase
         send_request(CMD_STAMP, stamp, 6'($urandom));
      end else if (pick < 65)
         send_request(CMD_RD_COARSE, {$urandom, $urandom}, 6'($urandom));
      else if (pick < 78)
         send_request(CMD_RD_FINE, {$urandom, $urandom}, 6'($urandom));
      else if (pick < 94)
         send_request(CMD_MODES, {$urandom, $urandom}, 6'($urandom));
      else if (pick < 96)
         send_request(CMD_CLEAR, {$urandom, $urandom}, 6'($urandom));
      else
         send_request(3'($urandom_range(5, 7)), {$urandom, $urandom}, 6'($urandom));
   endtask

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      logic [31:0] coarse_set [5];
      logic [31:0] base_set [5];
      logic [31:0] fine_set [5];
      logic [63:0] fw, ca, cb;
      coarse_set = '{32'd1000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd250};
      base_set = '{32'd0, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd500};
      fine_set = '{32'd100, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd37};
      histogram_board.reset_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (200) @(negedge clock);

      // Directed part at the reset settings.
      send_request(CMD_STAMP, 64'd5, '0);
      send_request(CMD_RD_FINE, '0, 6'd0);
      wait_drained();
      write_csr(REG_ENABLED, 32'd1);
      send_request(CMD_STAMP, 64'd0, '0);
      send_request(CMD_STAMP, 64'd50, '0);
      send_request(CMD_STAMP, '1, '0);
      send_request(CMD_STAMP, 64'd0, '0);
      send_request(CMD_STAMP, 64'd99999, '0);
      send_request(CMD_STAMP, 64'd100349, '0);
      send_request(CMD_STAMP, 64'd100699, '0);
      send_request(CMD_STAMP, 64'd101049, '0);
      send_request(CMD_RD_COARSE, '0, 6'd0);
      send_request(CMD_RD_COARSE, '1, 6'd63);
      send_request(CMD_RD_FINE, '0, 6'd0);
      send_request(CMD_RD_FINE, '0, 6'd63);
      send_request(CMD_RD_FINE, '0, 6'd3);
      send_request(CMD_MODES, '0, '0);
      send_request(3'd5, '1, '1);
      send_request(3'd6, '0, '0);
      send_request(3'd7, '1, '1);
      send_request(CMD_CLEAR, '0, '0);
      send_request(CMD_RD_FINE, '0, 6'd0);
      send_request(CMD_MODES, '0, '0);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         write_csr(REG_ENABLED, 32'd0);
         write_csr(REG_COARSE, coarse_set[phase]);
         write_csr(REG_BASE, base_set[phase]);
         write_csr(REG_FINE, fine_set[phase]);
         send_request(CMD_STAMP, {$urandom, $urandom}, '0);
         send_request(CMD_MODES, '0, '0);
         wait_drained();
         write_csr(REG_ENABLED, 32'd1);
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 55; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 55; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         fw = (fine_set[phase] == 0) ? 64'd1 : {32'd0, fine_set[phase]};
         ca = {32'd0, base_set[phase]} + fw * $urandom_range(2, 20);
         cb = {32'd0, base_set[phase]} + fw * $urandom_range(30, 60);
         for (int n = 0; n < 165; n++) begin
            random_request(ca, cb, fw);
            if (phase == 4 && n % 60 == 59) begin
               send_idle_pct = 20;
               recv_stall_pct = 20;
            end
         end
         wait_drained();
      end

      $display("covered %0d requests and %0d responses over five register settings",
               items_sent, histogram_board.responses_checked);
      $display("with idle and back-pressure phases; %0d mismatches",
               histogram_board.mismatches);
      if (histogram_board.mismatches == 0 && histogram_board.expected_responses.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule

>>> sim.f
+incdir+src
src/ihm_pkg.sv
src/ihm_ram.sv
src/ihm_fifo.sv
src/ihm_divider.sv
src/ihm_back.sv
src/ihm_front.sv
src/interval_histogram_mode_finder.sv
sim/testbench.sv
